// File: hdl/etc2_pkg.sv
// shared types, tables and helpers for the etc2 block decoder
package etc2_pkg;

  typedef struct packed {
    logic [63:0] color_block;
    logic [63:0] alpha_block;
  } etc2_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] pixel_x;
    logic [1:0] pixel_y;
    logic       last_pixel;
  } etc2_out_t;

  typedef enum logic [2:0] {
    MODE_INDIV  = 3'd0,
    MODE_DIFF   = 3'd1,
    MODE_T      = 3'd2,
    MODE_H      = 3'd3,
    MODE_PLANAR = 3'd4
  } etc2_mode_t;

  localparam logic [1:0] FMT_RGB8  = 2'd0;
  localparam logic [1:0] FMT_PUNCH = 2'd1;
  localparam logic [1:0] FMT_RGBA8 = 2'd2;
  localparam logic [1:0] REG_FORMAT = 2'd0;

  // classified block, passed front to back
  typedef struct packed {
    etc2_mode_t  mode;
    logic        opaque;
    logic        flip;
    logic        eac;
    logic [2:0]  t0;
    logic [2:0]  t1;
    logic [23:0] b0;
    logic [23:0] b1;
    logic [23:0] b2;
    logic [6:0]  tdist;
    logic [31:0] idx;
    logic [63:0] alpha_block;
  } etc2_blk_t;

  function automatic logic [7:0] ext4(input logic [3:0] v);
    return {v, v};
  endfunction
  function automatic logic [7:0] ext5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction
  function automatic logic [7:0] ext6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction
  function automatic logic [7:0] ext7(input logic [6:0] v);
    return {v, v[6]};
  endfunction

  function automatic logic [7:0] clamp10(input logic signed [9:0] v);
    logic [7:0] r;
    if (v < 0) r = 8'd0;
    else if (v > 10'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

  function automatic logic [6:0] dist_lut(input logic [2:0] i);
    logic [6:0] r;
    unique case (i)
      3'd0: r = 7'd3;
      3'd1: r = 7'd6;
      3'd2: r = 7'd11;
      3'd3: r = 7'd16;
      3'd4: r = 7'd23;
      3'd5: r = 7'd32;
      3'd6: r = 7'd41;
      default: r = 7'd64;
    endcase
    return r;
  endfunction

  // modifier magnitudes, small and large
  function automatic logic [7:0] mod_mag(input logic [2:0] t, input logic big);
    logic [7:0] r;
    unique case (t)
      3'd0: r = big ? 8'd8   : 8'd2;
      3'd1: r = big ? 8'd17  : 8'd5;
      3'd2: r = big ? 8'd29  : 8'd9;
      3'd3: r = big ? 8'd42  : 8'd13;
      3'd4: r = big ? 8'd60  : 8'd18;
      3'd5: r = big ? 8'd80  : 8'd24;
      3'd6: r = big ? 8'd106 : 8'd33;
      default: r = big ? 8'd183 : 8'd47;
    endcase
    return r;
  endfunction

  function automatic logic signed [4:0] alpha_lut(input logic [3:0] t, input logic [2:0] i);
    logic [31:0] row;
    logic [3:0]  m;
    unique case (t)
      4'd0:  row = 32'h369f_258e;
      4'd1:  row = 32'h37ad_269c;
      4'd2:  row = 32'h258d_147c;
      4'd3:  row = 32'h246d_135c;
      4'd4:  row = 32'h368c_257b;
      4'd5:  row = 32'h379b_268a;
      4'd6:  row = 32'h478b_367a;
      4'd7:  row = 32'h358b_247a;
      4'd8:  row = 32'h268a_1579;
      4'd9:  row = 32'h258a_1479;
      4'd10: row = 32'h248a_1379;
      4'd11: row = 32'h257a_1469;
      4'd12: row = 32'h347a_2369;
      4'd13: row = 32'h123a_0129;
      4'd14: row = 32'h4689_3578;
      default: row = 32'h3579_2468;
    endcase
    m = row[31 - 4 * i -: 4];
    return i[2] ? $signed({1'b0, m}) : -$signed({1'b0, m});
  endfunction

endpackage

// File: hdl/etc2_front.sv
// front end: takes a block, finds its mode and base colours
module etc2_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         texture_format,
  input  logic               in_valid,
  output logic               in_stall,
  input  etc2_pkg::etc2_in_t in_data,
  output logic               blk_valid,
  input  logic               blk_stall,
  output etc2_pkg::etc2_blk_t blk_data
);
  import etc2_pkg::*;

  logic [63:0] c;
  logic pt, diff, ovf_r, ovf_g, ovf_b;
  logic signed [6:0] sr, sg, sb;
  etc2_blk_t blk;
  logic [23:0] p0, p1;

  assign c = in_data.color_block;
  assign pt = texture_format == FMT_PUNCH;
  assign diff = c[33];
  assign sr = $signed({2'b0, c[63:59]}) + $signed({{4{c[58]}}, c[58:56]});
  assign sg = $signed({2'b0, c[55:51]}) + $signed({{4{c[50]}}, c[50:48]});
  assign sb = $signed({2'b0, c[47:43]}) + $signed({{4{c[42]}}, c[42:40]});
  assign ovf_r = sr < 0 || sr > 7'sd31;
  assign ovf_g = sg < 0 || sg > 7'sd31;
  assign ovf_b = sb < 0 || sb > 7'sd31;
  assign p0 = {ext4(c[62:59]), ext4({c[58:56], c[52]}), ext4({c[51], c[49:47]})};
  assign p1 = {ext4(c[46:43]), ext4(c[42:39]), ext4(c[38:35])};

  // classify block
  always_comb begin
    blk = '0;
    blk.opaque = !pt || diff;
    blk.flip = c[32];
    blk.eac = texture_format == FMT_RGBA8;
    blk.t0 = c[39:37];
    blk.t1 = c[36:34];
    blk.idx = c[31:0];
    blk.alpha_block = in_data.alpha_block;
    if (!(diff || pt)) blk.mode = MODE_INDIV;
    else if (ovf_r) blk.mode = MODE_T;
    else if (ovf_g) blk.mode = MODE_H;
    else if (ovf_b) blk.mode = MODE_PLANAR;
    else blk.mode = MODE_DIFF;
    unique case (blk.mode)
      MODE_INDIV: begin
        blk.b0 = {ext4(c[63:60]), ext4(c[55:52]), ext4(c[47:44])};
        blk.b1 = {ext4(c[59:56]), ext4(c[51:48]), ext4(c[43:40])};
      end
      MODE_DIFF: begin
        blk.b0 = {ext5(c[63:59]), ext5(c[55:51]), ext5(c[47:43])};
        blk.b1 = {ext5(sr[4:0]), ext5(sg[4:0]), ext5(sb[4:0])};
      end
      MODE_T: begin
        blk.b0 = {ext4({c[60:59], c[57:56]}), ext4(c[55:52]), ext4(c[51:48])};
        blk.b1 = {ext4(c[47:44]), ext4(c[43:40]), ext4(c[39:36])};
        blk.tdist = dist_lut({c[35:34], c[32]});
      end
      MODE_H: begin
        blk.b0 = p0;
        blk.b1 = p1;
        blk.tdist = dist_lut({c[34], c[32], p0 >= p1});
      end
      default: begin
        blk.b0 = {ext6(c[62:57]), ext7({c[56], c[54:49]}),
                  ext6({c[48], c[44:43], c[41:39]})};
        blk.b1 = {ext6({c[38:34], c[32]}), ext7(c[31:25]), ext6(c[24:19])};
        blk.b2 = {ext6(c[18:13]), ext7(c[12:6]), ext6(c[5:0])};
      end
    endcase
  end

  // output register
  assign in_stall = blk_valid && blk_stall;
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (!in_stall) begin
      blk_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      blk_data <= blk;
    end
  end

endmodule

// File: hdl/etc2_queue.sv
// two-entry queue of classified blocks between front and back
module etc2_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_valid,
  output logic                wr_stall,
  input  etc2_pkg::etc2_blk_t wr_data,
  output logic                rd_valid,
  input  logic                rd_stall,
  output etc2_pkg::etc2_blk_t rd_data
);
  import etc2_pkg::*;

  etc2_blk_t mem [2];
  logic wp, rp;
  logic [1:0] count;
  logic do_wr, do_rd;

  assign wr_stall = count == 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data = mem[rp];
  assign do_wr = wr_valid && !wr_stall;
  assign do_rd = rd_valid && !rd_stall;

  // storage and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wp <= !wp;
      if (do_rd) rp <= !rp;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
    if (do_wr) mem[wp] <= wr_data;
  end

  a_count: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overfilled");
  a_wr: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> count == $past(count) + 2'd1)
    else $error("queue count lost a write");

endmodule

// File: hdl/etc2_back.sv
// back end: walks the sixteen pixels of a block, two stages
module etc2_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 blk_valid,
  output logic                 blk_stall,
  input  etc2_pkg::etc2_blk_t  blk_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output etc2_pkg::etc2_out_t  out_data
);
  import etc2_pkg::*;

  logic [3:0] k;
  logic [1:0] x, y, pi;
  logic [3:0] pos;
  logic adv, s1_valid, s1_en;
  logic sub;
  logic [2:0] ai;
  etc2_blk_t b;
  logic signed [9:0] comp [3];
  logic [7:0] rgb [3];
  logic [7:0] al;
  logic signed [8:0] m;
  logic signed [9:0] d;
  logic signed [10:0] asum;
  // stage one registers
  logic signed [11:0] ps0 [3];
  logic signed [8:0] ps1 [3];
  logic [7:0] s1_rgb [3];
  logic [7:0] s1_al;
  logic s1_planar;
  logic [1:0] s1_x, s1_y;
  logic s1_last;
  logic [7:0] ao [3], ah [3], av [3];
  logic signed [12:0] pl [3];

  assign b = blk_data;
  assign x = k[1:0];
  assign y = k[3:2];
  assign pos = {x, y};
  assign pi = {b.idx[5'({1'b1, pos})], b.idx[5'(pos)]};
  assign sub = b.flip ? y[1] : x[1];
  assign ai = b.alpha_block[6'(45 - 3 * pos) +: 3];
  assign d = $signed({3'b0, b.tdist});
  assign s1_en = !s1_valid || !out_valid || !out_stall;
  assign adv = blk_valid && s1_en;
  assign blk_stall = !(adv && k == 4'd15);

  // per pixel colour selection, planar terms prepared
  always_comb begin
    m = pi[1] ? -$signed({1'b0, mod_mag(sub ? b.t1 : b.t0, pi[0])})
              :  $signed({1'b0, mod_mag(sub ? b.t1 : b.t0, pi[0])});
    if (!b.opaque && !pi[0]) m = '0;
    for (int i = 0; i < 3; i++) begin
      ao[i] = b.b0[23 - 8 * i -: 8];
      ah[i] = b.b1[23 - 8 * i -: 8];
      av[i] = b.b2[23 - 8 * i -: 8];
      unique case (b.mode)
        MODE_T: begin
          unique case (pi)
            2'd0: comp[i] = $signed({2'b0, ao[i]});
            2'd1: comp[i] = $signed({2'b0, ah[i]}) + d;
            2'd2: comp[i] = $signed({2'b0, ah[i]});
            default: comp[i] = $signed({2'b0, ah[i]}) - d;
          endcase
        end
        MODE_H: begin
          unique case (pi)
            2'd0: comp[i] = $signed({2'b0, ao[i]}) + d;
            2'd1: comp[i] = $signed({2'b0, ao[i]}) - d;
            2'd2: comp[i] = $signed({2'b0, ah[i]}) + d;
            default: comp[i] = $signed({2'b0, ah[i]}) - d;
          endcase
        end
        default: comp[i] = $signed({2'b0, sub ? ah[i] : ao[i]}) + m;
      endcase
      rgb[i] = clamp10(comp[i]);
      if (!b.opaque && pi == 2'd2 && b.mode != MODE_PLANAR) rgb[i] = 8'd0;
    end
    asum = $signed({3'b0, b.alpha_block[63:56]})
         + 11'(alpha_lut(b.alpha_block[51:48], ai))
         * 11'($signed({1'b0, b.alpha_block[55:52]}));
    if (asum < 0) al = 8'd0;
    else if (asum > 11'sd255) al = 8'd255;
    else al = asum[7:0];
    if (!b.eac) al = (!b.opaque && pi == 2'd2 && b.mode != MODE_PLANAR) ? 8'd0 : 8'd255;
  end

  // stage one: pixel counter and registered partial results
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= 4'd0;
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= blk_valid;
      if (blk_valid) k <= k + 4'd1;
    end
    if (adv) begin
      s1_planar <= b.mode == MODE_PLANAR;
      s1_x <= x;
      s1_y <= y;
      s1_last <= k == 4'd15;
      s1_al <= al;
      for (int i = 0; i < 3; i++) begin
        s1_rgb[i] <= rgb[i];
        ps0[i] <= $signed({10'b0, x}) * ($signed({4'b0, ah[i]}) - $signed({4'b0, ao[i]}))
                + $signed({2'b0, ao[i], 2'b10});
        ps1[i] <= $signed({1'b0, av[i]}) - $signed({1'b0, ao[i]});
      end
    end
  end

  // stage two: finish planar sum and register the result
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pl[i] = 13'(ps0[i]) + $signed({11'b0, s1_y}) * 13'(ps1[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
    if (s1_valid && (!out_valid || !out_stall)) begin
      out_data.red   <= s1_planar ? clamp10(10'(pl[0] >>> 2)) : s1_rgb[0];
      out_data.green <= s1_planar ? clamp10(10'(pl[1] >>> 2)) : s1_rgb[1];
      out_data.blue  <= s1_planar ? clamp10(10'(pl[2] >>> 2)) : s1_rgb[2];
      out_data.alpha <= s1_al;
      out_data.pixel_x <= s1_x;
      out_data.pixel_y <= s1_y;
      out_data.last_pixel <= s1_last;
    end
  end

  a_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last_pixel) |-> out_data.pixel_x == 2'd3 && out_data.pixel_y == 2'd3)
    else $error("last pixel flagged off the tile corner");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    (blk_valid && !blk_stall) |-> k == 4'd15)
    else $error("block released before sixteen pixels");

endmodule

// File: hdl/etc2_texture_block_decoder_unit.sv
// top level of the etc2 texture block decoder
//  channel   direction  payload
//  in        input      color_block, alpha_block
//  out       output     red, green, blue, alpha, pixel_x, pixel_y, last_pixel
//  cfg       apb        texture_format at address 0
// one pixel per cycle while the output is not stalled, sixteen pixels per block, set by the back end pixel counter
// a block passes the front output register, the queue and both back end stages before its first pixel appears
// rst is synchronous and clears control state and texture_format
// the front stage and a two-entry queue keep accepting while the output is stalled, until both are full
module etc2_texture_block_decoder_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  etc2_pkg::etc2_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output etc2_pkg::etc2_out_t out_data
);
  import etc2_pkg::*;

  logic [1:0] texture_format;
  logic f_valid, f_stall, q_valid, q_stall;
  etc2_blk_t f_data, q_data;

  // configuration register, unused code 3 decodes as rgb8
  assign pready = 1'b1;
  assign prdata = (paddr == REG_FORMAT[0]) ? {30'b0, texture_format} : 32'b0;
  always_ff @(posedge clk) begin
    if (rst) begin
      texture_format <= FMT_RGB8;
    end else if (psel && penable && pwrite && paddr == REG_FORMAT[0]) begin
      texture_format <= pwdata[1:0];
    end
  end

  etc2_front u_front (
    .clk, .rst, .texture_format, .in_valid, .in_stall, .in_data,
    .blk_valid(f_valid), .blk_stall(f_stall), .blk_data(f_data)
  );

  etc2_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_data),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_data)
  );

  etc2_back u_back (
    .clk, .rst, .blk_valid(q_valid), .blk_stall(q_stall), .blk_data(q_data),
    .out_valid, .out_stall, .out_data
  );

endmodule

// File: dv/etc2_texture_block_decoder_unit_tb.sv
// testbench for the etc2 texture block decoder: directed and random tiles against a predictor
module etc2_texture_block_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import etc2_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0, paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  etc2_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  etc2_out_t   out_data;

  etc2_texture_block_decoder_unit u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  etc2_out_t   pixel_q[$];
  logic [1:0]  fmt_model = FMT_RGB8;
  int          errors = 0;
  int          cycles = 0;
  int          tiles_sent = 0;
  int          pixels_seen = 0;
  localparam int CYCLE_LIMIT = 400000;

  // tables of the etc2 specification
  function automatic int modifier(int t, int i);
    int m[8][4] = '{'{2, 8, -2, -8}, '{5, 17, -5, -17}, '{9, 29, -9, -29},
      '{13, 42, -13, -42}, '{18, 60, -18, -60}, '{24, 80, -24, -80},
      '{33, 106, -33, -106}, '{47, 183, -47, -183}};
    return m[t][i];
  endfunction

  function automatic int distance(int i);
    int d[8] = '{3, 6, 11, 16, 23, 32, 41, 64};
    return d[i];
  endfunction

  function automatic int alpha_mod(int t, int i);
    int a[16][8] = '{
      '{-3, -6, -9, -15, 2, 5, 8, 14}, '{-3, -7, -10, -13, 2, 6, 9, 12},
      '{-2, -5, -8, -13, 1, 4, 7, 12}, '{-2, -4, -6, -13, 1, 3, 5, 12},
      '{-3, -6, -8, -12, 2, 5, 7, 11}, '{-3, -7, -9, -11, 2, 6, 8, 10},
      '{-4, -7, -8, -11, 3, 6, 7, 10}, '{-3, -5, -8, -11, 2, 4, 7, 10},
      '{-2, -6, -8, -10, 1, 5, 7, 9}, '{-2, -5, -8, -10, 1, 4, 7, 9},
      '{-2, -4, -8, -10, 1, 3, 7, 9}, '{-2, -5, -7, -10, 1, 4, 6, 9},
      '{-3, -4, -7, -10, 2, 3, 6, 9}, '{-1, -2, -3, -10, 0, 1, 2, 9},
      '{-4, -6, -8, -9, 3, 5, 7, 8}, '{-3, -5, -7, -9, 2, 4, 6, 8}};
    return a[t][i];
  endfunction

  function automatic int sat(int v);
    return v < 0 ? 0 : (v > 255 ? 255 : v);
  endfunction

  function automatic int bits(logic [63:0] w, int lo, int n);
    return int'((w >> lo) & ((64'd1 << n) - 1));
  endfunction

  function automatic int rep4(int v); return (v << 4) | v; endfunction
  function automatic int rep5(int v); return ((v << 3) | (v >> 2)) & 255; endfunction
  function automatic int rep6(int v); return ((v << 2) | (v >> 4)) & 255; endfunction
  function automatic int rep7(int v); return ((v << 1) | (v >> 6)) & 255; endfunction
  function automatic int sign3(int v); return (v & 4) ? v - 8 : v; endfunction

  // decode one tile into sixteen expected pixels
  task automatic predict_tile(input etc2_in_t blk);
    logic [63:0] c, a;
    logic        pt, eac, dif, flip, opaque;
    etc2_mode_t  mode;
    int          o[3], h[3], pal[4][3];
    int          i, k, s, d, x, y, pos, idx, sub, m, al, p0, p1;
    etc2_out_t   px;
    c = blk.color_block;
    a = blk.alpha_block;
    pt = fmt_model == FMT_PUNCH;
    eac = fmt_model == FMT_RGBA8;
    dif = c[33];
    flip = c[32];
    opaque = !pt || dif;
    mode = MODE_INDIV;
    if (dif || pt) begin
      mode = MODE_DIFF;
      for (i = 0; i < 3; i++) begin
        s = bits(c, 59 - 8 * i, 5) + sign3(bits(c, 56 - 8 * i, 3));
        if (s < 0 || s > 31) begin
          mode = etc2_mode_t'(2 + i);
          break;
        end
      end
    end
    case (mode)
      MODE_INDIV: begin
        for (i = 0; i < 3; i++) begin
          o[i] = rep4(bits(c, 60 - 8 * i, 4));
          h[i] = rep4(bits(c, 56 - 8 * i, 4));
        end
      end
      MODE_DIFF: begin
        for (i = 0; i < 3; i++) begin
          s = bits(c, 59 - 8 * i, 5);
          o[i] = rep5(s);
          h[i] = rep5(s + sign3(bits(c, 56 - 8 * i, 3)));
        end
      end
      MODE_T: begin
        o[0] = rep4((bits(c, 59, 2) << 2) | bits(c, 56, 2));
        o[1] = rep4(bits(c, 52, 4));
        o[2] = rep4(bits(c, 48, 4));
        h[0] = rep4(bits(c, 44, 4));
        h[1] = rep4(bits(c, 40, 4));
        h[2] = rep4(bits(c, 36, 4));
        d = distance((bits(c, 34, 2) << 1) | bits(c, 32, 1));
        for (i = 0; i < 3; i++) begin
          pal[0][i] = o[i];
          pal[1][i] = sat(h[i] + d);
          pal[2][i] = h[i];
          pal[3][i] = sat(h[i] - d);
        end
      end
      MODE_H: begin
        o[0] = rep4(bits(c, 59, 4));
        o[1] = rep4((bits(c, 56, 3) << 1) | bits(c, 52, 1));
        o[2] = rep4((bits(c, 51, 1) << 3) | bits(c, 47, 3));
        h[0] = rep4(bits(c, 43, 4));
        h[1] = rep4(bits(c, 39, 4));
        h[2] = rep4(bits(c, 35, 4));
        p0 = (o[0] << 16) | (o[1] << 8) | o[2];
        p1 = (h[0] << 16) | (h[1] << 8) | h[2];
        d = distance((bits(c, 34, 1) << 2) | (bits(c, 32, 1) << 1) | (p0 >= p1));
        for (i = 0; i < 3; i++) begin
          pal[0][i] = sat(o[i] + d);
          pal[1][i] = sat(o[i] - d);
          pal[2][i] = sat(h[i] + d);
          pal[3][i] = sat(h[i] - d);
        end
      end
      default: begin
        // planar: origin, horizontal and vertical colours
        o[0] = rep6(bits(c, 57, 6));
        o[1] = rep7((bits(c, 56, 1) << 6) | bits(c, 49, 6));
        o[2] = rep6((bits(c, 48, 1) << 5) | (bits(c, 43, 2) << 3) | bits(c, 39, 3));
        h[0] = rep6((bits(c, 34, 5) << 1) | bits(c, 32, 1));
        h[1] = rep7(bits(c, 25, 7));
        h[2] = rep6(bits(c, 19, 6));
        pal[0][0] = rep6(bits(c, 13, 6));
        pal[0][1] = rep7(bits(c, 6, 7));
        pal[0][2] = rep6(bits(c, 0, 6));
      end
    endcase
    for (k = 0; k < 16; k++) begin
      int rgb[3];
      x = k & 3;
      y = k >> 2;
      pos = x * 4 + y;
      idx = bits(c, pos, 1) | (bits(c, pos + 16, 1) << 1);
      al = 255;
      if (mode == MODE_PLANAR) begin
        for (i = 0; i < 3; i++) begin
          s = x * (h[i] - o[i]) + y * (pal[0][i] - o[i]) + 4 * o[i] + 2;
          rgb[i] = s < 0 ? 0 : sat(s >> 2);
        end
      end else if (!opaque && idx == 2) begin
        rgb = '{0, 0, 0};
        al = 0;
      end else if (mode == MODE_T || mode == MODE_H) begin
        for (i = 0; i < 3; i++) rgb[i] = pal[idx][i];
      end else begin
        sub = flip ? (y >> 1) : (x >> 1);
        m = modifier(sub ? bits(c, 34, 3) : bits(c, 37, 3), idx);
        if (!opaque && (idx & 1) == 0) m = 0;
        for (i = 0; i < 3; i++) rgb[i] = sat((sub ? h[i] : o[i]) + m);
      end
      if (eac)
        al = sat(bits(a, 56, 8) + alpha_mod(bits(a, 48, 4), bits(a, 45 - 3 * pos, 3))
                 * bits(a, 52, 4));
      px.red = 8'(rgb[0]);
      px.green = 8'(rgb[1]);
      px.blue = 8'(rgb[2]);
      px.alpha = 8'(al);
      px.pixel_x = 2'(x);
      px.pixel_y = 2'(y);
      px.last_pixel = k == 15;
      pixel_q.push_back(px);
    end
  endtask

  // cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // output side: random stall and field checks on each transfer
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      etc2_out_t exp_px;
      if (pixel_q.size() == 0) begin
        $error("pixel with no tile pending");
        errors++;
      end else begin
        exp_px = pixel_q.pop_front();
        pixels_seen++;
        if (out_data.red !== exp_px.red)
          $error("red expected %0d actual %0d", exp_px.red, out_data.red);
        if (out_data.green !== exp_px.green)
          $error("green expected %0d actual %0d", exp_px.green, out_data.green);
        if (out_data.blue !== exp_px.blue)
          $error("blue expected %0d actual %0d", exp_px.blue, out_data.blue);
        if (out_data.alpha !== exp_px.alpha)
          $error("alpha expected %0d actual %0d", exp_px.alpha, out_data.alpha);
        if (out_data.pixel_x !== exp_px.pixel_x)
          $error("pixel_x expected %0d actual %0d", exp_px.pixel_x, out_data.pixel_x);
        if (out_data.pixel_y !== exp_px.pixel_y)
          $error("pixel_y expected %0d actual %0d", exp_px.pixel_y, out_data.pixel_y);
        if (out_data.last_pixel !== exp_px.last_pixel)
          $error("last_pixel expected %0d actual %0d", exp_px.last_pixel,
                 out_data.last_pixel);
        if (out_data !== exp_px) errors++;
      end
    end
    // draw a wait per pixel, with quiet stretches
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      if (((cycles / 3000) % 3) == 0) begin
        stall_left <= 0;
        out_stall <= 1'b0;
      end else begin
        stall_left <= $urandom_range(0, 18);
        out_stall <= 1'b0;
      end
    end else begin
      out_stall <= 1'b0;
    end
  end

  // register write over apb
  task automatic write_format(input logic [1:0] fmt);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= REG_FORMAT[0];
    pwdata <= {30'd0, fmt};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    fmt_model = fmt;
  endtask

  // wait for the pipeline to drain before a register change
  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // one tile transfer with a random leading gap
  task automatic send_tile(input logic [63:0] c, input logic [63:0] a, input bit gaps = 1);
    etc2_in_t blk;
    int gap;
    gap = gaps ? $urandom_range(0, 18) : 0;
    if (gaps && ($urandom_range(0, 3) == 0)) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    blk.color_block = c;
    blk.alpha_block = a;
    in_valid <= 1'b1;
    in_data <= blk;
    predict_tile(blk);
    do @(posedge clk); while (in_stall);
    tiles_sent++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // colour block shaped towards a chosen mode
  function automatic logic [63:0] shaped_block(int sel);
    logic [63:0] c;
    c = rand64();
    case (sel)
      0: c[33] = 1'b0;
      1: begin c[33] = 1'b1; c[63:59] = 5'd12; c[55:51] = 5'd15; c[47:43] = 5'd9; end
      2: begin c[33] = 1'b1; c[63:59] = 5'd31; c[58:56] = 3'd3; end
      3: begin c[33] = 1'b1; c[63:59] = 5'd10; c[58:56] = 3'd0;
               c[55:51] = 5'd0; c[50:48] = 3'd4; end
      default: begin c[33] = 1'b1; c[63:59] = 5'd10; c[58:56] = 3'd0;
               c[55:51] = 5'd10; c[50:48] = 3'd0; c[47:43] = 5'd31; c[42:40] = 3'd2; end
    endcase
    return c;
  endfunction

  task automatic test_directed_rgb8();
    write_format(FMT_RGB8);
    send_tile(64'h0, 64'h0);
    send_tile('1, '1);
    for (int s = 0; s < 5; s++) send_tile(shaped_block(s), rand64());
    send_tile(64'hFFFF_FFFD_FFFF_FFFF, 64'h0);
    drain();
  endtask

  task automatic test_directed_punch();
    write_format(FMT_PUNCH);
    for (int s = 0; s < 5; s++) send_tile(shaped_block(s), rand64());
    send_tile(64'h0000_0000_0000_FFFF, 64'h0);
    send_tile(64'h0000_0000_FFFF_0000, 64'h0);
    drain();
  endtask

  task automatic test_directed_rgba8();
    write_format(FMT_RGBA8);
    send_tile(rand64(), 64'hFF0F_0000_0000_0000);
    send_tile(rand64(), 64'h80F0_FFFF_FFFF_FFFF);
    send_tile(rand64(), 64'h00FF_0000_0000_0000);
    send_tile(rand64(), 64'h7F3D_1234_5678_9ABC);
    drain();
    // unused format code decodes as rgb8
    write_format(2'd3);
    fmt_model = FMT_RGB8;
    send_tile(rand64(), rand64());
    drain();
  endtask

  task automatic test_random();
    logic [1:0] fmts[4] = '{FMT_RGB8, FMT_PUNCH, FMT_RGBA8, 2'd3};
    for (int p = 0; p < 4; p++) begin
      write_format(fmts[p]);
      if (fmts[p] == 2'd3) fmt_model = FMT_RGB8;
      for (int n = 0; n < 45; n++)
        send_tile(n % 4 == 0 ? rand64() : shaped_block($urandom_range(0, 4)), rand64());
      drain();
    end
  endtask

  task automatic test_back_to_back();
    write_format(FMT_RGBA8);
    for (int n = 0; n < 10; n++) send_tile(rand64(), rand64(), 0);
    // sender holds off until all pixels are out
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    for (int n = 0; n < 5; n++) send_tile(shaped_block(n), rand64(), 0);
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_rgb8();
    test_directed_punch();
    test_directed_rgba8();
    test_random();
    test_back_to_back();
    drain();
    repeat (40) @(posedge clk);
    $display("sent %0d tiles across all formats and modes, checked %0d pixels",
             tiles_sent, pixels_seen);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
